// File: rtl/core/ictf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the complementary tilt filter.
package ictf_pkg;

  localparam int CalSamples  = 3000;
  localparam int CordicSteps = 16;
  localparam int CordicIters = (CordicSteps > 24) ? 24 : CordicSteps;

  // field and datapath widths
  localparam int InW    = 16;
  localparam int MsW    = 16;
  localparam int WgtW   = 17;
  localparam int AngW   = 32;
  localparam int MulAW  = 34;
  localparam int MulBW  = 17;
  localparam int MulPW  = MulAW + MulBW;
  localparam int DivNW  = 50;
  localparam int DivDW  = 20;  // holds 131 * CalSamples for any sample count up to 4095
  localparam int SqW    = 48;
  localparam int RootW  = SqW / 2;
  localparam int CxW    = 28;
  localparam int CzW    = 25;
  localparam int DeltaW = 42;
  localparam int SumW   = 52;
  localparam int CsumW  = 28;
  localparam int CcntW  = 12;
  localparam int RawSh  = 17;  // raw * 131072
  localparam int RndSh  = 16;  // blend divides by 65536

  localparam int CalDivInt = 131 * CalSamples;
  localparam logic [DivDW-1:0] RateDiv  = DivDW'(131);
  localparam logic [DivDW-1:0] RateHalf = DivDW'(131 / 2);
  localparam logic [DivDW-1:0] MsDiv    = DivDW'(1000);
  localparam logic [DivDW-1:0] MsHalf   = DivDW'(1000 / 2);
  localparam logic [DivDW-1:0] CalDiv   = DivDW'(CalDivInt);
  localparam logic [DivDW-1:0] CalHalf  = DivDW'(CalDivInt / 2);

  localparam logic signed [AngW-1:0] OffXRst = 32'sd95027;
  localparam logic signed [AngW-1:0] OffYRst = 32'sd80609;
  localparam logic signed [AngW-1:0] OffZRst = -32'sd86508;
  localparam logic [WgtW-1:0] GyroWRst  = 17'd64225;
  localparam logic [WgtW-1:0] AccelWRst = 17'd1311;

  // atan(2^-i) in Q16.16 degrees
  localparam logic [21:0] AtanTab [24] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117305,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef enum logic {
    CFG_GYRO_WEIGHT  = 1'b0,
    CFG_ACCEL_WEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_P, ST_SQ_P_W, ST_SQ_Q, ST_SQ_Q_W, ST_SQRT, ST_SQRT_W,
    ST_CORD, ST_CORD_W, ST_RDIV, ST_RDIV_W, ST_RMUL, ST_RMUL_W, ST_DDIV,
    ST_DDIV_W, ST_BMG, ST_BMG_W, ST_BMA, ST_BMA_W, ST_BFIN, ST_YAW,
    ST_CAL, ST_CDIV, ST_CDIV_W, ST_OUT
  } state_e;

  function automatic logic signed [AngW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = $signed({{(SumW-AngW+1){1'b0}}, {(AngW-1){1'b1}}});
    lo = $signed({{(SumW-AngW+1){1'b1}}, {(AngW-1){1'b0}}});
    if (v > hi) return {1'b0, {(AngW-1){1'b1}}};
    if (v < lo) return {1'b1, {(AngW-1){1'b0}}};
    return v[AngW-1:0];
  endfunction

endpackage

// File: rtl/core/ictf_in_if.sv
`timescale 1ns / 1ps
// Input item channel: one raw six-axis sample plus kind and interval.
interface ictf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [ictf_pkg::InW-1:0]  acc_x;
  logic signed [ictf_pkg::InW-1:0]  acc_y;
  logic signed [ictf_pkg::InW-1:0]  acc_z;
  logic signed [ictf_pkg::InW-1:0]  rate_x;
  logic signed [ictf_pkg::InW-1:0]  rate_y;
  logic signed [ictf_pkg::InW-1:0]  rate_z;
  logic        [ictf_pkg::MsW-1:0]  elapsed_ms;

  modport source (output valid, kind, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                  elapsed_ms, input ready);
  modport sink   (input valid, kind, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                  elapsed_ms, output ready);
endinterface

// File: rtl/core/ictf_out_if.sv
`timescale 1ns / 1ps
// Result item channel: angle state and calibration flag.
interface ictf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ictf_pkg::AngW-1:0] roll_deg;
  logic signed [ictf_pkg::AngW-1:0] pitch_deg;
  logic signed [ictf_pkg::AngW-1:0] yaw_deg;
  logic                             offsets_updated;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, offsets_updated,
                  input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, offsets_updated,
                  output ready);
endinterface

// File: rtl/core/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// Complementary tilt filter: sequencer and state around serial arithmetic units.
// Update item: served by the bit-serial divider (six uses) and multiplier (eleven uses).
// Calibration item: accumulates the sample, and divides out the three offsets when it completes them.
// One item at a time; the next item is accepted while the last result waits.
// Reset (async, active low) clears angles, sums and count and loads default weights/offsets.
module imu_complementary_tilt_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ictf_pkg::WgtW-1:0]    cfg_wdata_i,
  ictf_in_if.sink                      in_i,
  ictf_out_if.source                   out_o
);

  function automatic logic [ictf_pkg::InW:0] mag16(input logic signed [ictf_pkg::InW-1:0] v);
    logic signed [ictf_pkg::InW:0] w;
    w = {v[ictf_pkg::InW-1], v};
    return w[ictf_pkg::InW] ? unsigned'(-w) : unsigned'(w);
  endfunction

  ictf_pkg::state_e state_q, state_d;

  logic [1:0]                          k_q;
  logic                                kind_q;
  logic signed [ictf_pkg::InW-1:0]     acc_q [3];
  logic signed [ictf_pkg::InW-1:0]     gyr_q [3];
  logic [ictf_pkg::MsW-1:0]            ms_q;
  logic [ictf_pkg::WgtW-1:0]           gw_q, aw_q;
  logic signed [ictf_pkg::AngW-1:0]    ang_q [3];
  logic signed [ictf_pkg::AngW-1:0]    off_q [3];
  logic signed [ictf_pkg::CsumW-1:0]   csum_q [3];
  logic [ictf_pkg::CcntW-1:0]          ccnt_q, ccnt_inc;
  logic                                upd_q, ov_q;

  logic [31:0]                         sq_q;
  logic signed [ictf_pkg::CzW-1:0]     tilt_q [2];
  logic signed [ictf_pkg::MulAW-1:0]   rate_q;
  logic                                neg_q;
  logic [ictf_pkg::DivNW-1:0]          dvd_q;
  logic signed [ictf_pkg::DeltaW-1:0]  delta_q;
  logic signed [ictf_pkg::MulPW-1:0]   prodg_q;
  logic signed [ictf_pkg::SumW-1:0]    s_q;
  logic signed [ictf_pkg::AngW-1:0]    oroll_q, opitch_q, oyaw_q;
  logic                                oupd_q;

  // unit handshakes and operands
  logic                                mul_start, mul_done;
  logic signed [ictf_pkg::MulAW-1:0]   mul_a;
  logic [ictf_pkg::MulBW-1:0]          mul_b;
  logic signed [ictf_pkg::MulPW-1:0]   mul_p;
  logic                                div_start, div_done;
  logic [ictf_pkg::DivNW-1:0]          div_n, div_q;
  logic [ictf_pkg::DivDW-1:0]          div_d;
  logic                                sq_start, sq_done;
  logic [ictf_pkg::RootW-1:0]          root;
  logic                                cor_start, cor_done;
  logic signed [ictf_pkg::CxW-1:0]     cor_y;
  logic signed [ictf_pkg::CzW-1:0]     cor_z;

  // derived datapath values
  logic [ictf_pkg::InW:0]              p_mag, q_mag, g_mag;
  logic signed [ictf_pkg::InW-1:0]     num, g_cur;
  logic signed [ictf_pkg::CsumW-1:0]   cs_cur;
  logic [ictf_pkg::CsumW-1:0]          cs_mag;
  logic signed [ictf_pkg::AngW-1:0]    t_sat;
  logic signed [ictf_pkg::MulPW-1:0]   p_mag_w;
  logic signed [ictf_pkg::MulAW-1:0]   q_rate;
  logic signed [ictf_pkg::SumW-1:0]    s_mag, s_rnd, s_res;
  logic signed [ictf_pkg::SumW-1:0]    cq;
  logic signed [ictf_pkg::DeltaW-1:0]  qd;
  logic                                accept, out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign ccnt_inc = ccnt_q + 1'b1;

  // roll: atan2(ay, |az,ax|); pitch: -atan2(ax, |az,ay|)
  assign p_mag  = mag16(acc_q[2]);
  assign q_mag  = mag16(k_q[0] ? acc_q[1] : acc_q[0]);
  assign num    = k_q[0] ? acc_q[0] : acc_q[1];
  assign cor_y  = {{(ictf_pkg::CxW-ictf_pkg::InW-8){num[ictf_pkg::InW-1]}}, num, 8'd0};
  assign g_cur  = gyr_q[k_q];
  assign g_mag  = mag16(g_cur);
  assign cs_cur = csum_q[k_q];
  assign cs_mag = cs_cur[ictf_pkg::CsumW-1] ? unsigned'(-cs_cur) : unsigned'(cs_cur);
  assign t_sat  = ictf_pkg::sat32(ictf_pkg::SumW'(ang_q[k_q]) + ictf_pkg::SumW'(delta_q));
  assign p_mag_w = mul_p[ictf_pkg::MulPW-1] ? -mul_p : mul_p;
  assign q_rate = $signed({1'b0, div_q[ictf_pkg::MulAW-2:0]});
  assign qd     = $signed({1'b0, div_q[ictf_pkg::DeltaW-2:0]});
  assign cq     = $signed({2'b00, div_q});
  // round half away from zero, divide by 65536
  assign s_mag  = s_q[ictf_pkg::SumW-1] ? -s_q : s_q;
  assign s_rnd  = (s_mag + ictf_pkg::SumW'(1 << (ictf_pkg::RndSh - 1))) >>> ictf_pkg::RndSh;
  assign s_res  = s_q[ictf_pkg::SumW-1] ? -s_rnd : s_rnd;

  ictf_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  ictf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .done_o(div_done), .quo_o(div_q)
  );

  ictf_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i({sq_q, 16'd0}),
    .done_o(sq_done), .root_o(root)
  );

  ictf_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .x_i(root), .y_i(cor_y),
    .done_o(cor_done), .z_o(cor_z)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ictf_pkg::ST_IDLE:   if (accept) state_d = in_i.kind ? ictf_pkg::ST_SQ_P : ictf_pkg::ST_CAL;
      ictf_pkg::ST_SQ_P:   state_d = ictf_pkg::ST_SQ_P_W;
      ictf_pkg::ST_SQ_P_W: if (mul_done) state_d = ictf_pkg::ST_SQ_Q;
      ictf_pkg::ST_SQ_Q:   state_d = ictf_pkg::ST_SQ_Q_W;
      ictf_pkg::ST_SQ_Q_W: if (mul_done) state_d = ictf_pkg::ST_SQRT;
      ictf_pkg::ST_SQRT:   state_d = ictf_pkg::ST_SQRT_W;
      ictf_pkg::ST_SQRT_W: if (sq_done) state_d = ictf_pkg::ST_CORD;
      ictf_pkg::ST_CORD:   state_d = ictf_pkg::ST_CORD_W;
      ictf_pkg::ST_CORD_W: if (cor_done) state_d = k_q[0] ? ictf_pkg::ST_RDIV : ictf_pkg::ST_SQ_P;
      ictf_pkg::ST_RDIV:   state_d = ictf_pkg::ST_RDIV_W;
      ictf_pkg::ST_RDIV_W: if (div_done) state_d = ictf_pkg::ST_RMUL;
      ictf_pkg::ST_RMUL:   state_d = ictf_pkg::ST_RMUL_W;
      ictf_pkg::ST_RMUL_W: if (mul_done) state_d = ictf_pkg::ST_DDIV;
      ictf_pkg::ST_DDIV:   state_d = ictf_pkg::ST_DDIV_W;
      ictf_pkg::ST_DDIV_W: if (div_done) state_d = (k_q == 2'd2) ? ictf_pkg::ST_YAW : ictf_pkg::ST_BMG;
      ictf_pkg::ST_BMG:    state_d = ictf_pkg::ST_BMG_W;
      ictf_pkg::ST_BMG_W:  if (mul_done) state_d = ictf_pkg::ST_BMA;
      ictf_pkg::ST_BMA:    state_d = ictf_pkg::ST_BMA_W;
      ictf_pkg::ST_BMA_W:  if (mul_done) state_d = ictf_pkg::ST_BFIN;
      ictf_pkg::ST_BFIN:   state_d = ictf_pkg::ST_RDIV;
      ictf_pkg::ST_YAW:    state_d = ictf_pkg::ST_OUT;
      ictf_pkg::ST_CAL: begin
        state_d = (ccnt_inc >= ictf_pkg::CcntW'(ictf_pkg::CalSamples)) ?
                  ictf_pkg::ST_CDIV : ictf_pkg::ST_OUT;
      end
      ictf_pkg::ST_CDIV:   state_d = ictf_pkg::ST_CDIV_W;
      ictf_pkg::ST_CDIV_W: if (div_done) state_d = (k_q == 2'd2) ? ictf_pkg::ST_OUT : ictf_pkg::ST_CDIV;
      ictf_pkg::ST_OUT:    if (out_free) state_d = ictf_pkg::ST_IDLE;
      default:             state_d = ictf_pkg::ST_IDLE;
    endcase
  end

  // unit starts and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = ictf_pkg::MsDiv;
    sq_start  = 1'b0;
    cor_start = 1'b0;
    unique case (state_q)
      ictf_pkg::ST_SQ_P: begin
        mul_start = 1'b1;
        mul_a     = $signed(ictf_pkg::MulAW'(p_mag));
        mul_b     = ictf_pkg::MulBW'(p_mag);
      end
      ictf_pkg::ST_SQ_Q: begin
        mul_start = 1'b1;
        mul_a     = $signed(ictf_pkg::MulAW'(q_mag));
        mul_b     = ictf_pkg::MulBW'(q_mag);
      end
      ictf_pkg::ST_SQRT: sq_start = 1'b1;
      ictf_pkg::ST_CORD: cor_start = 1'b1;
      ictf_pkg::ST_RDIV: begin
        div_start = 1'b1;
        div_n     = ictf_pkg::DivNW'({g_mag, {ictf_pkg::RawSh{1'b0}}}) +
                    ictf_pkg::DivNW'(ictf_pkg::RateHalf);
        div_d     = ictf_pkg::RateDiv;
      end
      ictf_pkg::ST_RMUL: begin
        mul_start = 1'b1;
        mul_a     = rate_q;
        mul_b     = ictf_pkg::MulBW'(ms_q);
      end
      ictf_pkg::ST_DDIV: begin
        div_start = 1'b1;
        div_n     = dvd_q;
        div_d     = ictf_pkg::MsDiv;
      end
      ictf_pkg::ST_BMG: begin
        mul_start = 1'b1;
        mul_a     = ictf_pkg::MulAW'(t_sat);
        mul_b     = gw_q;
      end
      ictf_pkg::ST_BMA: begin
        mul_start = 1'b1;
        mul_a     = ictf_pkg::MulAW'(tilt_q[k_q[0]]);
        mul_b     = aw_q;
      end
      ictf_pkg::ST_CDIV: begin
        div_start = 1'b1;
        div_n     = ictf_pkg::DivNW'({cs_mag, {ictf_pkg::RawSh{1'b0}}}) +
                    ictf_pkg::DivNW'(ictf_pkg::CalHalf);
        div_d     = ictf_pkg::CalDiv;
      end
      default: ;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ictf_pkg::ST_IDLE;
      k_q     <= '0;
      gw_q    <= ictf_pkg::GyroWRst;
      aw_q    <= ictf_pkg::AccelWRst;
      ang_q   <= '{default: '0};
      off_q   <= '{ictf_pkg::OffXRst, ictf_pkg::OffYRst, ictf_pkg::OffZRst};
      csum_q  <= '{default: '0};
      ccnt_q  <= '0;
      upd_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ictf_pkg::CFG_GYRO_WEIGHT:  gw_q <= cfg_wdata_i;
          ictf_pkg::CFG_ACCEL_WEIGHT: aw_q <= cfg_wdata_i;
        endcase
      end
      if (state_q == ictf_pkg::ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ictf_pkg::ST_IDLE: begin
          if (accept) begin
            k_q   <= '0;
            upd_q <= 1'b0;
          end
        end
        ictf_pkg::ST_CORD_W: if (cor_done) k_q <= k_q[0] ? 2'd0 : 2'd1;
        ictf_pkg::ST_BFIN: begin
          ang_q[k_q] <= ictf_pkg::sat32(s_res);
          k_q        <= k_q + 1'b1;
        end
        ictf_pkg::ST_YAW: begin
          ang_q[2] <= ictf_pkg::sat32(ictf_pkg::SumW'(ang_q[2]) + ictf_pkg::SumW'(delta_q));
        end
        ictf_pkg::ST_CAL: begin
          for (int i = 0; i < 3; i++) begin
            csum_q[i] <= csum_q[i] + ictf_pkg::CsumW'(gyr_q[i]);
          end
          ccnt_q <= ccnt_inc;
          k_q    <= '0;
        end
        ictf_pkg::ST_CDIV_W: begin
          if (div_done) begin
            off_q[k_q] <= ictf_pkg::sat32(neg_q ? -cq : cq);
            if (k_q == 2'd2) begin
              csum_q <= '{default: '0};
              ccnt_q <= '0;
              upd_q  <= 1'b1;
              k_q    <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // item latch, intermediates and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      acc_q  <= '{in_i.acc_x, in_i.acc_y, in_i.acc_z};
      gyr_q  <= '{in_i.rate_x, in_i.rate_y, in_i.rate_z};
      ms_q   <= in_i.elapsed_ms;
    end
    unique case (state_q)
      ictf_pkg::ST_SQ_P_W: if (mul_done) sq_q <= mul_p[31:0];
      ictf_pkg::ST_SQ_Q_W: if (mul_done) sq_q <= sq_q + mul_p[31:0];
      ictf_pkg::ST_CORD_W: if (cor_done) tilt_q[k_q[0]] <= k_q[0] ? -cor_z : cor_z;
      ictf_pkg::ST_RDIV:   neg_q <= g_cur[ictf_pkg::InW-1];
      ictf_pkg::ST_RDIV_W: if (div_done) rate_q <= (neg_q ? -q_rate : q_rate) -
                                                   ictf_pkg::MulAW'(off_q[k_q]);
      ictf_pkg::ST_RMUL_W: begin
        if (mul_done) begin
          neg_q <= mul_p[ictf_pkg::MulPW-1];
          dvd_q <= ictf_pkg::DivNW'(unsigned'(p_mag_w)) + ictf_pkg::DivNW'(ictf_pkg::MsHalf);
        end
      end
      ictf_pkg::ST_DDIV_W: if (div_done) delta_q <= neg_q ? -qd : qd;
      ictf_pkg::ST_BMG_W:  if (mul_done) prodg_q <= mul_p;
      ictf_pkg::ST_BMA_W:  if (mul_done) s_q <= ictf_pkg::SumW'(prodg_q) + ictf_pkg::SumW'(mul_p);
      ictf_pkg::ST_CDIV:   neg_q <= cs_cur[ictf_pkg::CsumW-1];
      ictf_pkg::ST_OUT: begin
        if (out_free) begin
          oroll_q  <= ang_q[0];
          opitch_q <= ang_q[1];
          oyaw_q   <= ang_q[2];
          oupd_q   <= upd_q && !kind_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready            = (state_q == ictf_pkg::ST_IDLE);
  assign out_o.valid           = ov_q;
  assign out_o.roll_deg        = oroll_q;
  assign out_o.pitch_deg       = opitch_q;
  assign out_o.yaw_deg         = oyaw_q;
  assign out_o.offsets_updated = oupd_q;

  // a result appears only from the result state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == ictf_pkg::ST_OUT)
    else $error("result valid rose outside result state");

  // completed calibration leaves the sample count cleared
  a_cal_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(ov_q) && out_o.offsets_updated) |-> ccnt_q == '0)
    else $error("offsets updated but calibration count not cleared");

  // yaw moves only in its integration step
  a_yaw_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ang_q[2]) |-> $past(state_q) == ictf_pkg::ST_YAW)
    else $error("yaw changed outside integration step");

endmodule

// File: rtl/core/ictf_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module ictf_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ictf_pkg::MulAW-1:0]   a_i,
  input  logic        [ictf_pkg::MulBW-1:0]   b_i,
  output logic                                done_o,
  output logic signed [ictf_pkg::MulPW-1:0]   prod_o
);
  localparam int CntW = $clog2(ictf_pkg::MulBW);

  logic                              busy_q, done_q;
  logic [CntW-1:0]                   cnt_q;
  logic signed [ictf_pkg::MulPW-1:0] mcand_q, acc_q;
  logic [ictf_pkg::MulBW-1:0]        mpl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ictf_pkg::MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= ictf_pkg::MulPW'(a_i);
      mpl_q   <= b_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      if (mpl_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q <= mcand_q <<< 1;
      mpl_q   <= mpl_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

// File: rtl/core/ictf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ictf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ictf_pkg::DivNW-1:0]   num_i,
  input  logic [ictf_pkg::DivDW-1:0]   den_i,
  output logic                         done_o,
  output logic [ictf_pkg::DivNW-1:0]   quo_o
);
  localparam int CntW = $clog2(ictf_pkg::DivNW);

  logic                       busy_q, done_q;
  logic [CntW-1:0]            cnt_q;
  logic [ictf_pkg::DivNW-1:0] num_q;
  logic [ictf_pkg::DivDW-1:0] den_q, rem_q;
  logic [ictf_pkg::DivDW:0]   rem_sh, rem_sub;
  logic                       ge;

  assign rem_sh  = {rem_q, num_q[ictf_pkg::DivNW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ictf_pkg::DivNW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[ictf_pkg::DivDW-1:0] : rem_sh[ictf_pkg::DivDW-1:0];
      num_q <= {num_q[ictf_pkg::DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

// File: rtl/core/ictf_isqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one result bit per cycle.
module ictf_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ictf_pkg::SqW-1:0]     val_i,
  output logic                         done_o,
  output logic [ictf_pkg::RootW-1:0]   root_o
);
  localparam int CntW = $clog2(ictf_pkg::RootW);

  logic                     busy_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic [ictf_pkg::SqW-1:0] v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ictf_pkg::RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= {2'b01, {(ictf_pkg::SqW-2){1'b0}}};
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ictf_pkg::RootW-1:0];
endmodule

// File: rtl/core/ictf_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC, one rotation per cycle, angle in Q16.16 degrees.
module ictf_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic        [ictf_pkg::RootW-1:0] x_i,
  input  logic signed [ictf_pkg::CxW-1:0]   y_i,
  output logic                              done_o,
  output logic signed [ictf_pkg::CzW-1:0]   z_o
);
  logic                            busy_q, done_q;
  logic [4:0]                      i_q;
  logic signed [ictf_pkg::CxW-1:0] x_q, y_q, xs, ys;
  logic signed [ictf_pkg::CzW-1:0] z_q, at;
  logic                            zero_in;

  assign zero_in = (x_i == '0) && (y_i == '0);
  assign xs      = x_q >>> i_q;
  assign ys      = y_q >>> i_q;
  assign at      = $signed(ictf_pkg::CzW'(ictf_pkg::AtanTab[i_q]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        i_q <= '0;
        // a null vector finishes at once with angle zero
        busy_q <= !zero_in;
        done_q <= zero_in;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == 5'(ictf_pkg::CordicIters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= $signed(ictf_pkg::CxW'(x_i));
      y_q <= y_i;
      z_q <= '0;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;
endmodule
